// ----- design/lct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types, constants and helpers for the line crossing tracker.
// ----------------------------------------------------------------------------
package lct_pkg;

    localparam int STATUS_W = 2;
    localparam int ANGLE_W  = 9;
    localparam int DIST_W   = 10;
    localparam int FDIST_W  = 11;
    localparam int THR_W    = 8;
    localparam int WIDE_W   = ANGLE_W + 1;

    // Line status codes; the unused code behaves as a T junction
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PLAIN = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TJUNC = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET = 8'd90;

    localparam logic signed [WIDE_W-1:0] HALF_TURN = 10'sd180;
    localparam logic signed [WIDE_W-1:0] FULL_TURN = 10'sd360;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [ANGLE_W-1:0] angle;
        logic [DIST_W-1:0]         distance;
    } t_reading;

    typedef struct packed {
        logic                      angle_valid;
        logic signed [ANGLE_W-1:0] field_angle;
        logic signed [FDIST_W-1:0] field_distance;
        logic                      inside_line;
        logic                      crossed_flag;
    } t_result;

    // Fold an angle back into -180..180 by at most one turn
    function automatic logic signed [WIDE_W-1:0] wrap_deg(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] y;
        y = x;
        if (y > HALF_TURN) begin
            y = y - FULL_TURN;
        end
        if (y < -HALF_TURN) begin
            y = y + FULL_TURN;
        end
        return y;
    endfunction

endpackage

// ----- design/lct_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lct_in_stage
// Input register: captures one sensor request and holds it until the
// result register can take the processed item.
// ----------------------------------------------------------------------------
module lct_in_stage (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [lct_pkg::STATUS_W-1:0]     i_status,
    input  wire logic [lct_pkg::ANGLE_W-1:0]      i_angle,
    input  wire logic [lct_pkg::DIST_W-1:0]       i_distance,
    input  wire logic                             i_advance,
    output logic                                  o_valid,
    output lct_pkg::t_reading                     o_reading
);
    import lct_pkg::*;

    logic     r_valid;
    t_reading r_reading;

    // Take a new request when empty or when the held one moves on
    assign o_s_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_reading.status   <= i_status;
            r_reading.angle    <= i_angle;
            r_reading.distance <= i_distance;
        end
    end

    assign o_valid   = r_valid;
    assign o_reading = r_reading;

endmodule
`default_nettype wire

// ----- design/lct_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lct_core
// Crossing state, threshold register and the per-reading logic that forms
// the field angle, signed distance and flags.
// ----------------------------------------------------------------------------
module lct_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [lct_pkg::THR_W-1:0]    i_cfg_wdata,
    input  wire logic                         i_fire,
    input  wire lct_pkg::t_reading            i_reading,
    output lct_pkg::t_result                  o_result
);
    import lct_pkg::*;

    logic [THR_W-1:0]          r_thr;
    logic                      r_over;
    logic                      r_prev_none;
    logic signed [ANGLE_W-1:0] r_last;

    logic                      on_line;
    logic                      on_t;
    logic                      plain;
    logic signed [WIDE_W-1:0]  angle_in;
    logic signed [WIDE_W-1:0]  last_ext;
    logic signed [WIDE_W-1:0]  diff;
    logic [WIDE_W-1:0]         diff_abs;
    logic                      toggle;
    logic                      n_over;
    logic signed [WIDE_W-1:0]  last_flip;
    logic signed [WIDE_W-1:0]  angle_flip;
    logic signed [FDIST_W-1:0] dist_ext;

    // Decode status; the high bit marks a T junction
    assign on_line = (i_reading.status != STATUS_NONE);
    assign on_t    = i_reading.status[1];
    assign plain   = on_line && !on_t;

    // Bring the raw angle into range and measure the jump
    assign angle_in = wrap_deg({i_reading.angle[ANGLE_W-1], i_reading.angle});
    assign last_ext = {r_last[ANGLE_W-1], r_last};
    assign diff     = wrap_deg(angle_in - last_ext);
    assign diff_abs = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);
    assign toggle   = plain && !r_prev_none
                      && (diff_abs > {{(WIDE_W-THR_W){1'b0}}, r_thr});
    assign n_over   = r_over ^ toggle;

    assign last_flip  = wrap_deg(last_ext + HALF_TURN);
    assign angle_flip = wrap_deg(angle_in + HALF_TURN);
    assign dist_ext   = $signed({1'b0, i_reading.distance});

    // Form the result with the updated flag
    always_comb begin
        o_result.angle_valid = 1'b1;
        o_result.field_angle = '0;
        if (!on_line) begin
            if (n_over) begin
                o_result.field_angle = r_last;
            end else begin
                o_result.angle_valid = 1'b0;
            end
        end else if (on_t) begin
            o_result.field_angle = n_over ? r_last : last_flip[ANGLE_W-1:0];
        end else begin
            o_result.field_angle = n_over ? angle_in[ANGLE_W-1:0]
                                          : angle_flip[ANGLE_W-1:0];
        end
        o_result.field_distance = n_over ? -dist_ext : dist_ext;
        o_result.inside_line    = !on_line && n_over;
        o_result.crossed_flag   = n_over;
    end

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // Advance the crossing state once per processed reading
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_over      <= 1'b0;
            r_prev_none <= 1'b1;
            r_last      <= '0;
        end else if (i_fire) begin
            r_over      <= n_over;
            r_prev_none <= !on_line;
            if (plain) begin
                r_last <= angle_in[ANGLE_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/lct_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lct_out_stage
// Result register: holds one finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module lct_out_stage (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire lct_pkg::t_result   i_result,
    output logic                    o_advance,
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output lct_pkg::t_result        o_result
);
    import lct_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room when empty or when the held result leaves this cycle
    assign o_advance = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

endmodule
`default_nettype wire

// ----- design/line_crossing_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_crossing_tracker
// Tracks whether the robot has crossed a field line from line-sensor readings.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one sensor reading per request. s_tuser carries the line
//   status, s_tdata the angle and distance.
//   Master channel: one result per reading, in order. m_tuser says whether
//   the field angle is valid, m_tdata carries angle, distance and flags.
//   Config port: i_cfg_we writes the crossing threshold in degrees; write it
//   only while no reading is in flight.
// Path: an accepted reading goes through the input register, then the
//   crossing logic, then the result register that drives o_m_tvalid.
// Throughput: one reading per clock unless stalled; flag closes in that cycle.
// Reset: the flag clears, the last reading counts as no line, the stored
//   angle is zero and the threshold returns to 90 degrees.
// Stall: while i_m_tready is low the result is held and one more reading is
//   taken into the input register; then o_s_tready drops.
// ----------------------------------------------------------------------------
module line_crossing_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [8:0] sensor_angle, [18:9] sensor_depth, [23:19] zero
    input  wire logic [23:0] i_s_tdata,
    // [1:0] line_status
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [8:0] field_angle, [19:9] field_distance, [20] inside_line,
    // [21] crossed_flag, [23:22] zero
    output logic [23:0]      o_m_tdata,
    // [0] angle_valid
    output logic [0:0]       o_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    import lct_pkg::*;

    logic     in_valid;
    logic     advance;
    t_reading reading;
    t_result  core_result;
    t_result  out_result;

    lct_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (i_s_tuser),
        .i_angle    (i_s_tdata[8:0]),
        .i_distance (i_s_tdata[18:9]),
        .i_advance  (advance),
        .o_valid    (in_valid),
        .o_reading  (reading)
    );

    lct_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (in_valid && advance),
        .i_reading   (reading),
        .o_result    (core_result)
    );

    lct_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_result   (core_result),
        .o_advance  (advance),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (out_result)
    );

    // Pack the result onto the master channel
    assign o_m_tdata = {2'b00,
                        out_result.crossed_flag,
                        out_result.inside_line,
                        out_result.field_distance,
                        out_result.field_angle};
    assign o_m_tuser = out_result.angle_valid;

endmodule
`default_nettype wire
